[hw/rtl/svt_pkg.sv]
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants for the skeletal vertex transform
// Bone table geometry, word selects and the request record that passes
// from the front end to the transform engine.
// ----------------------------------------------------------------------------
`default_nettype none
package svt_pkg;
	localparam int BoneCount = 64;
	localparam int BoneW     = 6;
	localparam int LevelW    = $clog2(BoneCount + 1);
	localparam logic [6:0] ParentNone = 7'h7f;

	typedef enum logic [3:0] {
		SEL_PX = 4'd0, SEL_PY = 4'd1, SEL_PZ = 4'd2,
		SEL_CX = 4'd3, SEL_SX = 4'd4, SEL_CY = 4'd5,
		SEL_SY = 4'd6, SEL_CZ = 4'd7, SEL_SZ = 4'd8,
		SEL_PARENT = 4'd9
	} word_sel_t;

	typedef enum logic {CMD_WRITE = 1'b0, CMD_XFORM = 1'b1} cmd_t;

	typedef struct packed {
		logic [BoneW-1:0] bone;
		logic [31:0]      x;
		logic [31:0]      y;
		logic [31:0]      z;
		logic             last;
	} xform_req_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_ROTX, ST_ROTY, ST_ROTZ, ST_NEXT, ST_DONE
	} eng_state_t;

	// Q16.16 product: bits 16..47 of the signed 64-bit product
	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		p = $signed(a) * $signed(b);
		return p[47:16];
	endfunction
endpackage
`default_nettype wire

[hw/rtl/skeletal_vertex_transform.sv]
// ----------------------------------------------------------------------------
// skeletal_vertex_transform: hierarchical bone skinning, Euler x-y-z
// Usage:
//   s_axis carries requests: command 0 writes one bone table word, command 1
//   transforms a vertex. m_axis returns one result per transform request.
//   Writes are taken only while no transform is queued or running.
//   Transform requests enter a two-entry queue; the engine walks the chain.
// Sequence: after an idle pickup the engine runs, per bone applied, a
//   check, a table read and three rotations (the last also takes the
//   parent step), then a final check and a result state; a bone-0 vertex
//   goes straight to the result. No new request is taken while busy, so
//   the rate follows chain depth; an overlong chain stops after 64 bones.
// Reset clears the control state; the bone table is undefined until written.
// When the receiver stalls, the result holds on m_axis and the queue keeps
//   taking up to two more transform requests.
// ----------------------------------------------------------------------------
`default_nettype none
module skeletal_vertex_transform import svt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: bone_index[5:0], word_select[9:6], word_value[41:10],
	// vertex_x[73:42], vertex_y[105:74], vertex_z[137:106], zero pad
	input  wire logic [143:0] s_axis_tdata,
	input  wire logic         s_axis_tuser,  // command
	input  wire logic         s_axis_tlast,  // last_vertex
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: out_x[31:0], out_y[63:32], out_z[95:64], status[96], zero pad
	output logic [103:0]      m_axis_tdata,
	output logic              m_axis_tlast   // last_out
);
	logic             wr_en, q_valid, q_ready, st;
	logic [BoneW-1:0] wr_bone;
	logic [3:0]       wr_sel;
	logic [31:0]      wr_value, ox, oy, oz;
	xform_req_t       in_req, q_req;

	assign in_req.bone = s_axis_tdata[5:0];
	assign in_req.x    = s_axis_tdata[73:42];
	assign in_req.y    = s_axis_tdata[105:74];
	assign in_req.z    = s_axis_tdata[137:106];
	assign in_req.last = s_axis_tlast;

	svt_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(s_axis_tuser), .bone_index(s_axis_tdata[5:0]),
		.word_select(s_axis_tdata[9:6]), .word_value(s_axis_tdata[41:10]),
		.in_req, .wr_en, .wr_bone, .wr_sel, .wr_value,
		.q_valid, .q_ready, .q_req
	);

	svt_engine u_engine (
		.clk, .arst_n, .wr_en, .wr_bone, .wr_sel, .wr_value,
		.q_valid, .q_ready, .q_req,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_x(ox), .out_y(oy), .out_z(oz), .out_status(st), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, st, oz, oy, ox};

	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tuser) |-> (q_ready && !q_valid))
		else $error("table write accepted during a transform");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> !m_axis_tvalid)
		else $error("engine took a request while presenting a result");
endmodule
`default_nettype wire

[hw/rtl/svt_front.sv]
// ----------------------------------------------------------------------------
// svt_front: request decode
// Accepts input requests, applies bone table writes and queues transform
// requests in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module svt_front import svt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             cmd,
	input  wire logic [BoneW-1:0] bone_index,
	input  wire logic [3:0]       word_select,
	input  wire logic [31:0]      word_value,
	input  wire xform_req_t       in_req,
	output logic                  wr_en,
	output logic [BoneW-1:0]      wr_bone,
	output logic [3:0]            wr_sel,
	output logic [31:0]           wr_value,
	output logic                  q_valid,
	input  wire logic             q_ready,
	output xform_req_t            q_req
);
	xform_req_t  fifo_q [2];
	logic        rd_ptr_q, wr_ptr_q;
	logic [1:0]  count_q;
	logic        push, pop;

	// hold writes while a transform is queued or running, so table order holds
	assign in_ready = (cmd == CMD_XFORM) ? (count_q != 2'd2) : (count_q == 2'd0 && q_ready);
	assign push     = in_valid && in_ready && cmd == CMD_XFORM;
	assign pop      = q_valid && q_ready;
	assign q_valid  = count_q != 2'd0;
	assign q_req    = fifo_q[rd_ptr_q];

	assign wr_en    = in_valid && in_ready && cmd == CMD_WRITE;
	assign wr_bone  = bone_index;
	assign wr_sel   = word_select;
	assign wr_value = word_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= in_req;
	end
endmodule
`default_nettype wire

[hw/rtl/svt_engine.sv]
// ----------------------------------------------------------------------------
// svt_engine: bone chain walker
// Holds the bone table and walks a vertex up its parent chain, one
// rotation axis per cycle with four shared multipliers.
// ----------------------------------------------------------------------------
`default_nettype none
module svt_engine import svt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [BoneW-1:0] wr_bone,
	input  wire logic [3:0]       wr_sel,
	input  wire logic [31:0]      wr_value,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire xform_req_t       q_req,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [31:0]           out_x,
	output logic [31:0]           out_y,
	output logic [31:0]           out_z,
	output logic                  out_status,
	output logic                  out_last
);
	logic [287:0] geo_mem [BoneCount];
	logic [6:0]   par_mem [BoneCount];
	logic [287:0] geo_rd_q;
	logic [6:0]   par_rd_q;

	eng_state_t        state_q, state_d;
	logic [BoneW-1:0]  bone_q;
	logic [LevelW-1:0] levels_q;
	logic [31:0]       x_q, y_q, z_q;
	logic              last_q, status_q;
	logic [31:0]       px, py, pz, cxv, sxv, cyv, syv, czv, szv;
	logic [31:0]       ma, mb, mc, md, ca, sa;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_sel)
				SEL_PX:     geo_mem[wr_bone][31:0]    <= wr_value;
				SEL_PY:     geo_mem[wr_bone][63:32]   <= wr_value;
				SEL_PZ:     geo_mem[wr_bone][95:64]   <= wr_value;
				SEL_CX:     geo_mem[wr_bone][127:96]  <= wr_value;
				SEL_SX:     geo_mem[wr_bone][159:128] <= wr_value;
				SEL_CY:     geo_mem[wr_bone][191:160] <= wr_value;
				SEL_SY:     geo_mem[wr_bone][223:192] <= wr_value;
				SEL_CZ:     geo_mem[wr_bone][255:224] <= wr_value;
				SEL_SZ:     geo_mem[wr_bone][287:256] <= wr_value;
				SEL_PARENT: par_mem[wr_bone] <= wr_value[6:0];
				default: ;
			endcase
		end
		geo_rd_q <= geo_mem[bone_q];
		par_rd_q <= par_mem[bone_q];
	end

	assign {szv, czv, syv, cyv, sxv, cxv, pz, py, px} = geo_rd_q;

	// operand select per axis: (u,v) -> (c*u - s*v, s*u + c*v)
	always_comb begin
		ca = cxv; sa = sxv; ma = z_q; mb = y_q;
		case (state_q)
			ST_ROTX: begin ca = cxv; sa = sxv; ma = z_q; mb = y_q; end
			ST_ROTY: begin ca = cyv; sa = syv; ma = y_q; mb = x_q; end
			ST_ROTZ: begin ca = czv; sa = szv; ma = x_q; mb = z_q; end
			default: ;
		endcase
		mc = qmul(ca, ma) - qmul(sa, mb);
		md = qmul(sa, ma) + qmul(ca, mb);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_NEXT;
			ST_NEXT: begin
				if (bone_q == '0 || status_q) state_d = ST_DONE;
				else if (levels_q == LevelW'(BoneCount)) state_d = ST_DONE;
				else state_d = ST_READ;
			end
			ST_READ: state_d = ST_ROTX;
			ST_ROTX: state_d = ST_ROTY;
			ST_ROTY: state_d = ST_ROTZ;
			ST_ROTZ: state_d = ST_NEXT;
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = state_q == ST_IDLE;
		out_valid = state_q == ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bone_q <= q_req.bone; x_q <= q_req.x; y_q <= q_req.y; z_q <= q_req.z;
				last_q <= q_req.last; levels_q <= '0; status_q <= 1'b0;
			end
			ST_NEXT: if (bone_q != '0 && levels_q == LevelW'(BoneCount)) status_q <= 1'b1;
			ST_READ: begin
				x_q <= x_q - px; y_q <= y_q - py; z_q <= z_q - pz;
				levels_q <= levels_q + 1'b1;
			end
			ST_ROTX: begin z_q <= mc; y_q <= md; end
			ST_ROTY: begin y_q <= mc; x_q <= md; end
			ST_ROTZ: begin
				x_q <= mc + px; z_q <= md + pz; y_q <= y_q + py;
				if (par_rd_q == ParentNone) bone_q <= '0;
				else bone_q <= par_rd_q[BoneW-1:0];
			end
			default: ;
		endcase
	end

	assign out_x = x_q;
	assign out_y = y_q;
	assign out_z = z_q;
	assign out_status = status_q;
	assign out_last = last_q;
endmodule
`default_nettype wire
